// ----- src/ghalloc_pkg.sv -----
// ----------------------------------------------------------------------------
// ghalloc_pkg
// Shared types and codes for the generational handle allocator: item
// structs, request modes, status codes and the sequencer states.
// ----------------------------------------------------------------------------
package ghalloc_pkg;

  // Request modes carried in the input item.
  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_CHECK   = 2'd2;

  // Status codes carried in the result item.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_STALE = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  slot_index;
    logic [31:0] handle_generation;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  granted_index;
    logic [31:0] granted_generation;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_EVAL
  } state_t;

  // Where an allocate request takes its slot from.
  typedef enum logic [1:0] {
    SRC_STACK,
    SRC_FRESH,
    SRC_FULL
  } src_t;

endpackage

// ----- src/generational_handle_allocator.sv -----
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Hands out handles made of a slot index and a generation, takes them back
// and checks them, using a LIFO free stack and a generation table in RAM.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+--------------------------
//   in_     | input     | in_valid / in_stall    | in_item  (mode, index, gen)
//   out_    | output    | out_valid / out_stall  | out_item (status, index, gen)
//
// Sequencing: one item is worked on at a time; a new one is taken only after
// the last is evaluated. For release, check and allocation of a never-used
// slot, the sequencer goes from IDLE to EVAL, and the result register loads
// as EVAL is left. An allocation that pops the free stack passes through POP
// first, because the popped index must come out of the stack RAM before the
// generation RAM can be read. The result sits in an output register, so the
// next item is taken while a finished result still waits on out_stall; that
// item's evaluation then waits as long as the stall lasts. Reset clears the
// counters and the sequencer at once; neither RAM needs a clearing pass.
//
module generational_handle_allocator #(
  parameter int SLOTS    = 256,
  parameter int GEN_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  ghalloc_pkg::in_item_t  in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ghalloc_pkg::out_item_t out_item
);

  // Index width, counter width (counters must hold SLOTS itself) and the
  // width used to compare an 8-bit request index against the counters.
  localparam int IW    = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
  localparam int GW    = GEN_BITS + 1;

  // Sequencer and bookkeeping registers.
  ghalloc_pkg::state_t   state_r, state_nxt;
  ghalloc_pkg::in_item_t req_r;
  ghalloc_pkg::src_t     src_r, src_nxt;
  logic [CNT_W-1:0]      free_count_r, free_count_nxt;
  logic [CNT_W-1:0]      hw_r, hw_nxt;
  logic                  out_valid_r;
  ghalloc_pkg::out_item_t out_item_r, out_item_nxt;

  // Control decoded from the state.
  logic accept;
  logic eval_go;
  logic gen_rd_en;

  // RAM ports. The generation table holds {live, generation} per slot; an
  // entry is written when its slot is first handed out, and read data of
  // entries at or above the high-water mark is never used.
  logic          stk_wr_en;
  logic [IW-1:0] stk_wr_addr;
  logic [IW-1:0] stk_rd_addr;
  logic [IW-1:0] stk_rd_data;
  logic          gen_wr_en;
  logic [IW-1:0] gen_wr_addr;
  logic [GW-1:0] gen_wr_data;
  logic [IW-1:0] gen_rd_addr;
  logic [GW-1:0] gen_rd_data;

  // Evaluation datapath.
  logic [GEN_BITS-1:0] cur_gen;
  logic [GEN_BITS-1:0] bumped_gen;
  logic                cur_live;
  logic                unknown_idx;
  logic                gen_match;
  logic                rel_ok;
  logic [IW-1:0]       fresh_slot;
  logic [IW-1:0]       req_slot;

  ghalloc_ram #(.DEPTH(SLOTS), .WIDTH(IW)) u_stack (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (req_slot),
    .rd_en   (accept),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data)
  );

  ghalloc_ram #(.DEPTH(SLOTS), .WIDTH(GW)) u_gen (
    .clk     (clk),
    .wr_en   (gen_wr_en),
    .wr_addr (gen_wr_addr),
    .wr_data (gen_wr_data),
    .rd_en   (gen_rd_en),
    .rd_addr (gen_rd_addr),
    .rd_data (gen_rd_data)
  );

  // --------------------------------------------------------------------------
  // Sequencer outputs. An item is taken only in IDLE; evaluation waits while
  // a previous result is still held in the output register and stalled.
  // --------------------------------------------------------------------------
  always_comb begin
    in_stall  = (state_r != ghalloc_pkg::S_IDLE);
    accept    = in_valid && (state_r == ghalloc_pkg::S_IDLE);
    eval_go   = (state_r == ghalloc_pkg::S_EVAL) && !(out_valid_r && out_stall);
    gen_rd_en = accept || (state_r == ghalloc_pkg::S_POP);
  end

  // Next state. Only an allocation with a non-empty stack passes through POP
  // to fetch the popped index.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ghalloc_pkg::S_IDLE: begin
        if (accept) begin
          if (in_item.mode == ghalloc_pkg::MODE_ALLOC && free_count_r != '0) begin
            state_nxt = ghalloc_pkg::S_POP;
          end else begin
            state_nxt = ghalloc_pkg::S_EVAL;
          end
        end
      end
      ghalloc_pkg::S_POP: begin
        state_nxt = ghalloc_pkg::S_EVAL;
      end
      ghalloc_pkg::S_EVAL: begin
        if (eval_go) begin
          state_nxt = ghalloc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ghalloc_pkg::S_IDLE;
      end
    endcase
  end

  // Allocation source is decided from the counters at acceptance; they do
  // not move until this item is evaluated.
  always_comb begin
    if (free_count_r != '0) begin
      src_nxt = ghalloc_pkg::SRC_STACK;
    end else if (hw_r < CNT_W'(SLOTS)) begin
      src_nxt = ghalloc_pkg::SRC_FRESH;
    end else begin
      src_nxt = ghalloc_pkg::SRC_FULL;
    end
  end

  // RAM read addresses. The stack is read at its top on acceptance; the
  // generation table at the requested index on acceptance, or at the popped
  // index in the following cycle, in POP.
  assign stk_rd_addr = IW'(free_count_r - CNT_W'(1));
  assign gen_rd_addr = (state_r == ghalloc_pkg::S_POP) ? stk_rd_data
                                                       : IW'(in_item.slot_index);

  // --------------------------------------------------------------------------
  // Evaluation: read data is valid in S_EVAL and stays put, since neither RAM
  // is read again until the next item is accepted.
  // --------------------------------------------------------------------------
  assign cur_gen     = gen_rd_data[GEN_BITS-1:0];
  assign cur_live    = gen_rd_data[GEN_BITS];
  assign bumped_gen  = cur_gen + GEN_BITS'(1);
  assign fresh_slot  = IW'(hw_r);
  assign req_slot    = IW'(req_r.slot_index);
  assign unknown_idx = (CMP_W'(req_r.slot_index) >= CMP_W'(hw_r));
  // A handle with bits above GEN_BITS never matches.
  assign gen_match   = (req_r.handle_generation == 32'(cur_gen));
  assign rel_ok      = eval_go && (req_r.mode == ghalloc_pkg::MODE_RELEASE) &&
                       !unknown_idx && cur_live && gen_match;

  always_comb begin
    out_item_nxt   = '0;
    free_count_nxt = free_count_r;
    hw_nxt         = hw_r;
    stk_wr_en      = 1'b0;
    stk_wr_addr    = IW'(free_count_r);
    gen_wr_en      = 1'b0;
    gen_wr_addr    = req_slot;
    gen_wr_data    = {1'b1, cur_gen};

    case (req_r.mode)
      ghalloc_pkg::MODE_ALLOC: begin
        case (src_r)
          ghalloc_pkg::SRC_STACK: begin
            // Pop: the slot keeps the generation it got on release.
            out_item_nxt.status             = ghalloc_pkg::ST_OK;
            out_item_nxt.granted_index      = 8'(stk_rd_data);
            out_item_nxt.granted_generation = 32'(cur_gen);
            gen_wr_en      = eval_go;
            gen_wr_addr    = stk_rd_data;
            gen_wr_data    = {1'b1, cur_gen};
            free_count_nxt = eval_go ? free_count_r - CNT_W'(1) : free_count_r;
          end
          ghalloc_pkg::SRC_FRESH: begin
            // First use of a slot starts its generation at zero.
            out_item_nxt.status             = ghalloc_pkg::ST_OK;
            out_item_nxt.granted_index      = 8'(fresh_slot);
            out_item_nxt.granted_generation = '0;
            gen_wr_en   = eval_go;
            gen_wr_addr = fresh_slot;
            gen_wr_data = {1'b1, {GEN_BITS{1'b0}}};
            hw_nxt      = eval_go ? hw_r + CNT_W'(1) : hw_r;
          end
          default: begin
            out_item_nxt.status = ghalloc_pkg::ST_FULL;
          end
        endcase
      end
      ghalloc_pkg::MODE_RELEASE, ghalloc_pkg::MODE_CHECK: begin
        out_item_nxt.granted_index = req_r.slot_index;
        if (unknown_idx) begin
          out_item_nxt.status = ghalloc_pkg::ST_STALE;
        end else if (!cur_live || !gen_match) begin
          out_item_nxt.status             = ghalloc_pkg::ST_STALE;
          out_item_nxt.granted_generation = 32'(cur_gen);
        end else if (req_r.mode == ghalloc_pkg::MODE_RELEASE) begin
          // Bump the generation, drop the live bit and push the index.
          out_item_nxt.status             = ghalloc_pkg::ST_OK;
          out_item_nxt.granted_generation = 32'(bumped_gen);
          gen_wr_en   = eval_go;
          gen_wr_data = {1'b0, bumped_gen};
          if (free_count_r < CNT_W'(SLOTS)) begin
            stk_wr_en      = eval_go;
            free_count_nxt = eval_go ? free_count_r + CNT_W'(1) : free_count_r;
          end
        end else begin
          out_item_nxt.status             = ghalloc_pkg::ST_OK;
          out_item_nxt.granted_generation = 32'(cur_gen);
        end
      end
      default: begin
        out_item_nxt.status        = ghalloc_pkg::ST_STALE;
        out_item_nxt.granted_index = req_r.slot_index;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ghalloc_pkg::S_IDLE;
      free_count_r <= '0;
      hw_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_count_r <= free_count_nxt;
      hw_r         <= hw_nxt;
      if (eval_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_item;
      src_r <= src_nxt;
    end
    if (eval_go) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTH
  // Every free index was handed out once, so the stack never outgrows the
  // high-water mark.
  a_free_le_hw: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= hw_r)
    else $error("free stack deeper than high-water mark");

  a_hw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r <= CNT_W'(SLOTS))
    else $error("high-water mark beyond slot count");

  a_eval_result: assert property (@(posedge clk) disable iff (!rst_n)
    eval_go |=> out_valid_r && (state_r == ghalloc_pkg::S_IDLE))
    else $error("evaluation did not produce a result");

  a_release_push: assert property (@(posedge clk) disable iff (!rst_n)
    rel_ok |=> free_count_r == $past(free_count_r) + CNT_W'(1))
    else $error("successful release did not push the free stack");

  a_pop_then_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ghalloc_pkg::S_POP) |=> (state_r == ghalloc_pkg::S_EVAL))
    else $error("stack pop not followed by evaluation");
`endif

endmodule

// ----- src/ghalloc_ram.sv -----
// ----------------------------------------------------------------------------
// ghalloc_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read and a read enable.
// ----------------------------------------------------------------------------
module ghalloc_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
